[design/bba_pkg.sv]
// Shared constants and types for the bitmap block allocator.
// No dependencies; imported by bitmap_block_allocator.
`default_nettype none

package bba_pkg;

    localparam int INDEX_W  = 12;  // block number field width
    localparam int TOTAL_W  = 13;  // total_blocks register width
    localparam int STATUS_W = 2;
    localparam int APB_W    = 32;
    localparam int S_DATA_W = 16;  // block_index padded to bytes
    localparam int M_DATA_W = 16;  // granted_block + status padded to bytes

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_NO_SPACE     = 2'd1,
        STATUS_ALREADY_FREE = 2'd2,
        STATUS_RANGE        = 2'd3
    } t_status;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    localparam logic REG_TOTAL_BLOCKS = 1'b0;  // byte address 0

endpackage

`default_nettype wire

[design/bitmap_block_allocator.sv]
// First-fit block allocator over a used/free bitmap held in a word memory.
// Depends on bba_pkg (constants, status codes).
// After reset a clearing pass writes every bitmap word to zero, s_tready low
// meanwhile. An allocate walks the bitmap one word per cycle through a pipelined
// memory read. A free walks to the word holding the block, block_index /
// WORD_BITS; an out-of-range free is decided at the first word read. One item at
// a time; the result register frees the input side as soon as the result is loaded.
// Reset is synchronous, active low.
`default_nettype none

module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_BITS  = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // stream in
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [bba_pkg::S_DATA_W-1:0]      s_tdata,   // [11:0] block_index
    input  wire                               s_tuser,   // [0] mode
    // stream out
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [bba_pkg::M_DATA_W-1:0]      m_tdata,   // [11:0] granted_block, [13:12] status
    // config
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [0:0]                        paddr,
    input  wire  [bba_pkg::APB_W-1:0]         pwdata,
    output logic [bba_pkg::APB_W-1:0]         prdata,
    output logic                              pready
);
    import bba_pkg::*;

    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int AW1 = $clog2(NUM_WORDS + 1);
    localparam int OFF_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int SPAN_W = $clog2(NUM_WORDS * WORD_BITS + 1);
    localparam int CNT_W = (SPAN_W > TOTAL_W) ? SPAN_W : TOTAL_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state               r_state;
    logic [AW-1:0]        r_clr_addr;
    logic [TOTAL_W-1:0]   r_total;
    logic                 r_mode;
    logic [INDEX_W-1:0]   r_idx;
    logic [AW1-1:0]       r_iss_addr;
    logic [CNT_W-1:0]     r_iss_base;
    logic                 r_chk_valid;
    logic [AW1-1:0]       r_chk_addr;
    logic [CNT_W-1:0]     r_chk_base;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_out_valid;
    logic [INDEX_W-1:0]   r_out_block;
    t_status              r_out_status;

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];

    logic [CNT_W-1:0]     limit;
    logic [CNT_W-1:0]     rem;
    logic [CNT_W-1:0]     idx_ext;
    logic [CNT_W-1:0]     diff;
    logic [WORD_BITS-1:0] free_mask;
    logic                 free_hit;
    logic [OFF_W-1:0]     free_pos;
    logic [CNT_W-1:0]     grant_sum;
    logic                 decide;
    logic                 do_write;
    t_status              n_status;
    logic [INDEX_W-1:0]   n_block;
    logic [WORD_BITS-1:0] n_word;
    logic                 out_busy;
    logic                 done;
    logic                 advance;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr == REG_TOTAL_BLOCKS);
    assign pready = 1'b1;
    assign prdata = (paddr == REG_TOTAL_BLOCKS) ? APB_W'(r_total) : '0;

    assign s_tready = (r_state == ST_IDLE);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = M_DATA_W'({r_out_status, r_out_block});

    always_comb begin
        limit = (CNT_W'(r_total) > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(r_total);
        rem   = limit - r_chk_base;
        idx_ext = CNT_W'(r_idx);
        diff    = idx_ext - r_chk_base;

        // free bits of this word that lie below the block count
        for (int k = 0; k < WORD_BITS; k++) begin
            free_mask[k] = !r_rd_data[k] && (CNT_W'(k) < rem);
        end
        free_hit = |free_mask;
        free_pos = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--) begin
            if (free_mask[k]) begin
                free_pos = OFF_W'(k);
            end
        end
        grant_sum = r_chk_base + CNT_W'(free_pos);

        decide   = 1'b0;
        do_write = 1'b0;
        n_status = STATUS_OK;
        n_block  = '0;
        n_word   = r_rd_data;
        if (r_mode == MODE_ALLOC) begin
            if (r_chk_base >= limit) begin
                decide   = 1'b1;
                n_status = STATUS_NO_SPACE;
            end else if (free_hit) begin
                decide   = 1'b1;
                do_write = 1'b1;
                n_block  = grant_sum[INDEX_W-1:0];
                n_word   = r_rd_data | (WORD_BITS'(1) << free_pos);
            end
        end else begin
            if (idx_ext >= limit) begin
                decide   = 1'b1;
                n_status = STATUS_RANGE;
            end else if ((r_chk_base <= idx_ext) && (diff < CNT_W'(WORD_BITS))) begin
                decide = 1'b1;
                if (!r_rd_data[diff[OFF_W-1:0]]) begin
                    n_status = STATUS_ALREADY_FREE;
                end else begin
                    do_write = 1'b1;
                    n_word   = r_rd_data & ~(WORD_BITS'(1) << diff[OFF_W-1:0]);
                end
            end
        end

        out_busy = r_out_valid && !m_tready;
        done     = (r_state == ST_SCAN) && r_chk_valid && decide && !out_busy;
        // hold the pipeline while a finished result waits for the output register
        advance  = (r_state == ST_SCAN) && !(r_chk_valid && decide);

        mem_we    = (r_state == ST_CLEAR) || (done && do_write);
        mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_chk_addr[AW-1:0];
        mem_wdata = (r_state == ST_CLEAR) ? '0 : n_word;
    end

    // bitmap memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (advance) begin
            r_rd_data <= r_mem[r_iss_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= TOTAL_RESET;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_total <= pwdata[TOTAL_W-1:0];
            end
            if (r_out_valid && m_tready && !done) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(NUM_WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        r_state     <= ST_SCAN;
                        r_mode      <= s_tuser;
                        r_idx       <= s_tdata[INDEX_W-1:0];
                        r_iss_addr  <= '0;
                        r_iss_base  <= '0;
                        r_chk_valid <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    if (done) begin
                        r_state      <= ST_IDLE;
                        r_chk_valid  <= 1'b0;
                        r_out_valid  <= 1'b1;
                        r_out_block  <= n_block;
                        r_out_status <= n_status;
                    end else if (advance) begin
                        r_chk_valid <= 1'b1;
                        r_chk_addr  <= r_iss_addr;
                        r_chk_base  <= r_iss_base;
                        if (r_iss_addr != AW1'(NUM_WORDS)) begin
                            r_iss_addr <= r_iss_addr + AW1'(1);
                            r_iss_base <= r_iss_base + CNT_W'(WORD_BITS);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking bench for bitmap_block_allocator: random and directed
// allocate/free items, results compared against a bitmap tracker in the bench.
// Depends on bba_pkg and the allocator RTL.
`default_nettype none

module tb;
    import bba_pkg::*;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = MAX_BLOCKS / WORD_BITS;

    typedef struct packed {
        logic [INDEX_W-1:0] block;
        t_status            status;
    } t_grant;

    // Tracks the used/free map and the grants still owed by the block.
    class block_usage_tracker;
        bit                 block_used [MAX_BLOCKS];
        logic [TOTAL_W-1:0] total_blocks;
        t_grant             expected_grants [$];
        int                 error_count;

        function new();
            foreach (block_used[b]) block_used[b] = 1'b0;
            total_blocks = TOTAL_RESET;
            error_count  = 0;
        endfunction

        task report(string what);
            $display("tb: mismatch: %s", what);
            error_count++;
        endtask

        function int unsigned block_limit();
            return (total_blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_blocks);
        endfunction

        function void set_total(logic [TOTAL_W-1:0] value);
            total_blocks = value;
        endfunction

        function int unsigned pending();
            return expected_grants.size();
        endfunction

        // Random block that is currently in use below the limit, -1 if none.
        function int pick_used_block();
            int unsigned lim;
            int unsigned start;
            int unsigned b;
            lim = block_limit();
            if (lim == 0) return -1;
            start = $urandom_range(0, lim - 1);
            for (int unsigned k = 0; k < lim; k++) begin
                b = (start + k) % lim;
                if (block_used[b]) return int'(b);
            end
            return -1;
        endfunction

        function void note_request(t_mode mode, logic [INDEX_W-1:0] idx);
            t_grant      res;
            int unsigned lim;
            lim       = block_limit();
            res.block = '0;
            if (mode == MODE_ALLOC) begin
                res.status = STATUS_NO_SPACE;
                for (int unsigned b = 0; b < lim; b++) begin
                    if (!block_used[b]) begin
                        block_used[b] = 1'b1;
                        res.block     = INDEX_W'(b);
                        res.status    = STATUS_OK;
                        break;
                    end
                end
            end else if (idx >= lim) begin
                res.status = STATUS_RANGE;
            end else if (!block_used[idx]) begin
                res.status = STATUS_ALREADY_FREE;
            end else begin
                block_used[idx] = 1'b0;
                res.status      = STATUS_OK;
            end
            expected_grants.push_back(res);
        endfunction

        task check_grant(logic [M_DATA_W-1:0] data);
            t_grant             want;
            logic [INDEX_W-1:0] got_block;
            logic [1:0]         got_status;
            got_block  = data[INDEX_W-1:0];
            got_status = data[INDEX_W+STATUS_W-1:INDEX_W];
            if (expected_grants.size() == 0) begin
                report($sformatf("result 0x%04h with nothing outstanding", data));
                return;
            end
            want = expected_grants.pop_front();
            if (got_block !== want.block)
                report($sformatf("granted_block %0d, want %0d", got_block, want.block));
            if (got_status !== want.status)
                report($sformatf("status %0d, want %0d", got_status, want.status));
        endtask
    endclass

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [11:0] block_index
    logic                s_tuser  = 1'b0; // [0] mode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [11:0] granted_block, [13:12] status
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [0:0]          paddr    = '0;
    logic [APB_W-1:0]    pwdata   = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    block_usage_tracker sb;
    bit                 idle_on = 1'b1;

    bitmap_block_allocator #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BITS  (WORD_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stall bursts, steady ready once idling is off.
    initial begin
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (idle_on && hold == 0 && $urandom_range(0, 5) == 0)
                hold = $urandom_range(1, 19);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) sb.check_grant(m_tdata);
        end
    end

    initial begin
        #6000000;
        $display("tb: failure");
        $finish;
    end

    // Tasks below are entered right after a rising edge.
    task automatic send_item(t_mode mode, logic [INDEX_W-1:0] idx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= S_DATA_W'(idx);
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(mode, idx);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(logic wr, logic [0:0] addr, logic [APB_W-1:0] data,
                              output logic [APB_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // return to the idle bus state between accesses
        @(posedge i_clk);
    endtask

    // Write the block count register and read it back.
    task automatic program_total(logic [APB_W-1:0] value);
        logic [APB_W-1:0] rd;
        apb_access(1'b1, REG_TOTAL_BLOCKS, value, rd);
        sb.set_total(value[TOTAL_W-1:0]);
        apb_access(1'b0, REG_TOTAL_BLOCKS, '0, rd);
        if (rd !== APB_W'(sb.total_blocks))
            sb.report($sformatf("total_blocks read 0x%0h, want 0x%0h", rd, sb.total_blocks));
    endtask

    task automatic random_item(int unsigned alloc_pct);
        int          pick;
        int unsigned lim;
        int unsigned roll;
        lim = sb.block_limit();
        if ($urandom_range(0, 99) < alloc_pct) begin
            send_item(MODE_ALLOC, INDEX_W'($urandom_range(0, 4095)));
        end else begin
            roll = $urandom_range(0, 99);
            pick = sb.pick_used_block();
            if (roll < 55 && pick >= 0)
                send_item(MODE_FREE, INDEX_W'(pick));
            else if (roll < 65)
                send_item(MODE_FREE, INDEX_W'(lim - $urandom_range(0, 1)));
            else
                send_item(MODE_FREE, INDEX_W'($urandom_range(0, 4095)));
        end
    endtask

    initial begin
        logic [APB_W-1:0]   rd;
        logic [TOTAL_W-1:0] total;
        int unsigned        n_items;
        int unsigned        alloc_pct;

        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default block count, empty map.
        send_item(MODE_ALLOC, 12'd0);
        send_item(MODE_ALLOC, 12'd0);
        send_item(MODE_ALLOC, 12'hFFF);     // index ignored on allocate
        send_item(MODE_FREE,  12'd1);
        send_item(MODE_FREE,  12'd1);       // double free
        send_item(MODE_FREE,  12'hFFF);     // top block, never used
        send_item(MODE_FREE,  12'd0);
        send_item(MODE_ALLOC, 12'd0);
        drain_results();

        // Zero blocks: nothing to allocate, every free out of range.
        program_total(32'd0);
        send_item(MODE_ALLOC, 12'd0);
        send_item(MODE_FREE,  12'd0);
        send_item(MODE_FREE,  12'hFFF);
        drain_results();

        // Count above capacity is clamped.
        program_total(32'd8191);
        send_item(MODE_FREE,  12'hFFF);
        send_item(MODE_ALLOC, 12'd0);
        drain_results();

        // Write to a non-register address leaves the count alone.
        apb_access(1'b1, 1'b1, 32'd3, rd);
        program_total(32'hFFFF_E005);       // upper bits dropped, count 5
        send_item(MODE_ALLOC, 12'd0);
        send_item(MODE_ALLOC, 12'd0);
        send_item(MODE_ALLOC, 12'd0);       // full
        send_item(MODE_FREE,  12'd5);       // at the limit
        send_item(MODE_FREE,  12'd4);
        send_item(MODE_ALLOC, 12'd0);
        drain_results();

        program_total(32'd4096);
        send_item(MODE_FREE,  12'hFFF);
        send_item(MODE_FREE,  12'd2);
        drain_results();

        for (int p = 0; p < 10; p++) begin
            n_items   = 45;
            alloc_pct = 50;
            case (p)
                0: begin total = 13'd4096; n_items = 120; alloc_pct = 90; end
                1: total = 13'd20;
                2: total = 13'd0;
                3: total = 13'd8191;
                4: total = 13'd33;
                5: total = TOTAL_W'($urandom_range(0, 8191));
                6: total = 13'd1;
                7: begin total = 13'd4096; alloc_pct = 40; end
                8: total = TOTAL_W'($urandom_range(0, 200));
                default: begin total = 13'd4096; idle_on = 1'b0; end
            endcase
            program_total({APB_W'($urandom) & ~APB_W'(13'h1FFF)} | APB_W'(total));
            repeat (n_items) random_item(alloc_pct);
            drain_results();
        end

        repeat (NUM_WORDS + 4) @(posedge i_clk);
        if (sb.error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
design/bba_pkg.sv
design/bitmap_block_allocator.sv
bench/tb.sv
